[design/assert_macros.svh]
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// A condition that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

[design/efs_pkg.sv]
`default_nettype none

package efs_pkg;

    localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
    localparam logic [7:0] PERCENT_CHAR   = 8'h25;
    localparam logic [7:0] DEFAULT_DELIM  = 8'h5E;

    // Escape sequence progress.
    localparam logic [1:0] ESC_NONE  = 2'd0;
    localparam logic [1:0] ESC_PCT   = 2'd1;
    localparam logic [1:0] ESC_DIGIT = 2'd2;

    // Positions of the flags in the result tuser.
    localparam int unsigned USER_BYTE_VALID = 0;
    localparam int unsigned USER_LINE_END   = 1;
    localparam int unsigned USER_BAD_ESCAPE = 2;

    typedef struct packed {
        logic       bad_escape;
        logic       line_end;
        logic       field_end;
        logic       byte_valid;
        logic [7:0] out_byte;
    } result_t;

    // Hex digit value as a 5-bit two's complement number; all ones means not a digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h1F;
        if (c inside {[8'h30:8'h39]}) begin
            v = 5'(c - 8'h30);
        end
        else if (c inside {[8'h41:8'h46]}) begin
            v = 5'(c - 8'h37);
        end
        else if (c inside {[8'h61:8'h66]}) begin
            v = 5'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[design/escaped_field_splitter.sv]
`default_nettype none
`include "assert_macros.svh"

// Channel   Direction  Signals                    Beat content
// s_        in         s_tvalid/s_tready/s_tdata  tdata[7:0] in_byte, tlast end_of_line
// m_        out        m_tvalid/m_tready/m_tdata  tdata[7:0] out_byte, tlast field_end,
//                      m_tuser/m_tlast            tuser {bad_escape, line_end, byte_valid}
// cfg_      in         cfg_valid/cfg_ready        cfg_data[7:0] delimiter
//
// One input beat is taken per clock cycle unless a held result waits on m_tready. Its
// result, if it has one, shows on the output register in the cycle after acceptance;
// the decode is byte compares and an 8-bit add in front of that register.
// rst_n clears the escape state, sets the delimiter to caret and empties the output.
// A stalled output blocks input only while a result is still held and m_tready is low.
// The configuration channel is always ready; write it only while the block is idle.
module escaped_field_splitter (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Input stream
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] in_byte
    input  wire logic       s_tlast,    // end_of_line
    // Result stream
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] out_byte
    output logic            m_tlast,    // field_end
    output logic [2:0]      m_tuser,    // [0] byte_valid, [1] line_end, [2] bad_escape
    // Delimiter register write
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic [7:0] delimiter_reg;
    logic [1:0] escape_phase_reg, escape_phase_next;
    logic [4:0] high_digit_reg, high_digit_next;
    logic [7:0] prev_byte_reg, prev_byte_next;
    logic       line_start_reg, line_start_next;

    logic              out_valid_reg;
    efs_pkg::result_t  result_reg;
    efs_pkg::result_t  result_next;
    logic              has_result;

    logic       accept;
    logic       delim_hit;
    logic       pending;
    logic [4:0] low_digit;

    // The input moves whenever the output register is empty or is being emptied.
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign pending   = (escape_phase_reg == efs_pkg::ESC_PCT) ||
                       (escape_phase_reg == efs_pkg::ESC_DIGIT);
    // A delimiter right after a backslash is escaped, except at the start of a line.
    assign delim_hit = (s_tdata == delimiter_reg) &&
                       (line_start_reg || (prev_byte_reg != efs_pkg::BACKSLASH_CHAR));
    assign low_digit = efs_pkg::hex_value(s_tdata);

    always_comb
    begin
        escape_phase_next = escape_phase_reg;
        high_digit_next   = high_digit_reg;
        prev_byte_next    = prev_byte_reg;
        line_start_next   = line_start_reg;
        result_next       = '0;
        has_result        = 1'b0;

        if (accept)
        begin
            if (s_tlast)
            begin
                // End of line closes the last field; a half-read escape is dropped.
                has_result             = 1'b1;
                result_next.field_end  = 1'b1;
                result_next.line_end   = 1'b1;
                result_next.bad_escape = pending;
                escape_phase_next      = efs_pkg::ESC_NONE;
                high_digit_next        = '0;
                prev_byte_next         = '0;
                line_start_next        = 1'b1;
            end
            else if (delim_hit)
            begin
                has_result             = 1'b1;
                result_next.field_end  = 1'b1;
                result_next.bad_escape = pending;
                escape_phase_next      = efs_pkg::ESC_NONE;
                prev_byte_next         = s_tdata;
                line_start_next        = 1'b0;
            end
            else
            begin
                prev_byte_next  = s_tdata;
                line_start_next = 1'b0;
                case (escape_phase_reg)
                    efs_pkg::ESC_PCT:
                    begin
                        high_digit_next   = low_digit;
                        escape_phase_next = efs_pkg::ESC_DIGIT;
                    end
                    efs_pkg::ESC_DIGIT:
                    begin
                        // high*16 + low, both sign-extended, wrapped to 8 bits.
                        has_result             = 1'b1;
                        result_next.byte_valid = 1'b1;
                        result_next.out_byte   = {high_digit_reg[3:0], 4'b0000} +
                                                 {{3{low_digit[4]}}, low_digit};
                        result_next.bad_escape = (high_digit_reg == 5'h1F) ||
                                                 (low_digit == 5'h1F);
                        escape_phase_next      = efs_pkg::ESC_NONE;
                    end
                    default:
                    begin
                        escape_phase_next = efs_pkg::ESC_NONE;
                        if (s_tdata == efs_pkg::PERCENT_CHAR)
                        begin
                            escape_phase_next = efs_pkg::ESC_PCT;
                        end
                        else
                        begin
                            has_result             = 1'b1;
                            result_next.byte_valid = 1'b1;
                            result_next.out_byte   = s_tdata;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg    <= efs_pkg::DEFAULT_DELIM;
            escape_phase_reg <= efs_pkg::ESC_NONE;
            high_digit_reg   <= '0;
            prev_byte_reg    <= '0;
            line_start_reg   <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                delimiter_reg <= cfg_data;
            end
            escape_phase_reg <= escape_phase_next;
            high_digit_reg   <= high_digit_next;
            prev_byte_reg    <= prev_byte_next;
            line_start_reg   <= line_start_next;
            if (has_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload has no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (has_result)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg.out_byte;
    assign m_tlast  = result_reg.field_end;
    assign m_tuser  = {result_reg.bad_escape, result_reg.line_end, result_reg.byte_valid};

    // A beat carries either a byte or a field end, never both.
    `ASSERT_NEVER(a_byte_xor_end, clk, rst_n,
        m_tvalid && m_tlast && m_tuser[efs_pkg::USER_BYTE_VALID])
    // A line end is always also a field end.
    `ASSERT_PROP(a_line_end_ends_field, clk, rst_n,
        (m_tvalid && m_tuser[efs_pkg::USER_LINE_END]) |-> m_tlast)
    // After an end-of-line beat the parser is back at a clean line start.
    `ASSERT_PROP(a_eol_clears_state, clk, rst_n,
        (accept && s_tlast) |=>
        (line_start_reg && (escape_phase_reg == efs_pkg::ESC_NONE)))
    // A percent outside an escape opens one and gives no result.
    `ASSERT_PROP(a_percent_opens_escape, clk, rst_n,
        (accept && !s_tlast && !delim_hit && (escape_phase_reg == efs_pkg::ESC_NONE) &&
         (s_tdata == efs_pkg::PERCENT_CHAR)) |=>
        ((escape_phase_reg == efs_pkg::ESC_PCT) && !$past(has_result)))
    // A taken result with nothing new behind it empties the output register.
    `ASSERT_PROP(a_output_drains, clk, rst_n,
        (m_tvalid && m_tready && !has_result) |=> !m_tvalid)

endmodule

`default_nettype wire
